// File: design/ordered_list_delete_by_value_top_defines.svh
// Assertion macros shared by the checker of the ordered list block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_LIST_DELETE_BY_VALUE_TOP_DEFINES_SVH
`define ORDERED_LIST_DELETE_BY_VALUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLDV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLDV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/oldv_pkg.sv
// Package for the ordered list block: command and status codes and the
// control and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oldv_pkg;

  // Width of the occupancy and removed-count result fields.
  localparam int OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INS_HEAD  = 2'd0,
    CMD_INS_TAIL  = 2'd1,
    CMD_REM_FIRST = 2'd2,
    CMD_REM_ALL   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic insert;
    logic scan;
    logic finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_remove;
    logic scan_end;
  } sts_t;

endpackage

`default_nettype wire

// File: design/oldv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oldv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/oldv_ctrl.sv
// Controller state machine of the ordered list block.
// Depends on oldv_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module oldv_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire oldv_pkg::sts_t sts,
  output oldv_pkg::ctl_t     ctl,
  output logic               busy,
  output logic               done
);
  import oldv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = sts.in_remove ? S_SCAN : S_INS;
        end
      end
      S_INS: begin
        ctl.insert = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          ctl.finish = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// File: design/oldv_dp.sv
// Datapath of the ordered list block: circular storage with head pointer and
// count, compaction scan and result registers. Depends on oldv_pkg and oldv_ram.
`timescale 1ns / 1ps
`default_nettype none

module oldv_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire oldv_pkg::ctl_t              ctl,
  input  wire logic [1:0]                  cmd,
  input  wire logic signed [31:0]          value,
  output oldv_pkg::sts_t                   sts,
  output logic [1:0]                       status,
  output logic [oldv_pkg::OUT_W-1:0]       occupancy,
  output logic [oldv_pkg::OUT_W-1:0]       removed_count
);
  import oldv_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0]  head;
  logic [CW-1:0]  count;
  logic [CW-1:0]  rd_idx;
  logic [CW-1:0]  wr_idx;
  logic [CW-1:0]  gone;
  logic [1:0]     cmd_q;
  logic [31:0]    value_q;
  status_t        status_q;
  logic [OUT_W-1:0] removed_q;

  logic           full;
  logic [AW-1:0]  head_dec;
  logic [AW-1:0]  tail_addr;
  logic           match;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;

  // Map head plus a position onto the circular storage.
  function automatic logic [AW-1:0] wrap_pos(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
    return t[AW-1:0];
  endfunction

  // Pointer arithmetic and match detection.
  always_comb begin
    full      = (count == CW'(CAPACITY));
    head_dec  = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
    tail_addr = wrap_pos(SW'(head) + SW'(count));
    match     = (ram_rdata == value_q) && ((cmd_q == CMD_REM_ALL) || (gone == '0));
  end

  // Storage ports: inserts write the new value, the scan writes back kept entries.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_addr;
    ram_wdata = value_q;
    if (ctl.insert && !full) begin
      ram_we    = 1'b1;
      ram_waddr = (cmd_q == CMD_INS_HEAD) ? head_dec : tail_addr;
    end else if (ctl.scan && !match) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_pos(SW'(head) + SW'(wr_idx));
      ram_wdata = ram_rdata;
    end
    ram_raddr = ctl.load ? head : wrap_pos(SW'(head) + SW'(rd_idx) + SW'(1));
  end

  oldv_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // List state, scan counters and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctl.insert && !full) begin
        if (cmd_q == CMD_INS_HEAD) begin
          head <= head_dec;
        end
        count <= count + CW'(1);
      end
      if (ctl.finish) begin
        count <= wr_idx;
      end
    end

    if (ctl.load) begin
      cmd_q   <= cmd;
      value_q <= value;
      rd_idx  <= '0;
      wr_idx  <= '0;
      gone    <= '0;
    end
    if (ctl.insert) begin
      status_q  <= full ? ST_FULL : ST_DONE;
      removed_q <= '0;
    end
    if (ctl.scan) begin
      rd_idx <= rd_idx + CW'(1);
      if (match) begin
        gone <= gone + CW'(1);
      end else begin
        wr_idx <= wr_idx + CW'(1);
      end
    end
    if (ctl.finish) begin
      status_q  <= (gone == '0) ? ST_NOMATCH : ST_DONE;
      removed_q <= OUT_W'(gone);
    end
  end

  assign sts.in_remove = cmd[1];
  assign sts.scan_end  = (rd_idx == count);

  assign status        = status_q;
  assign occupancy     = OUT_W'(count);
  assign removed_count = removed_q;

endmodule

`default_nettype wire

// File: design/ordered_list_delete_by_value_top.sv
// Top level of the ordered list block: controller and datapath.
// Depends on oldv_pkg, oldv_ctrl, oldv_dp and oldv_ram.
//
// Usage:
//   Command channel: drive cmd and value with start high; the item is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   occupancy and removed_count valid; the receiver cannot stall it.
// Sequencing:
//   Inserts: done is registered from the insert state that follows the
//   accepting edge, and a new item can be accepted in the cycle done is high.
//   Removals: after the accepting edge the scan state walks the count entries
//   present before the command, then done rises with the result; the scan
//   reads one entry per cycle from the single read port of the storage and
//   writes kept entries back in order.
// Storage is circular with a head pointer, so inserts at either end are a
// single write. Reset clears the head pointer, the count and the state
// machine; the entry storage itself is not cleared and needs no clearing pass.
// Occupancy and removed_count are reported modulo 32.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_delete_by_value_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            cmd,
  input  wire logic signed [31:0]    value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [oldv_pkg::OUT_W-1:0] occupancy,
  output logic [oldv_pkg::OUT_W-1:0] removed_count
);
  import oldv_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Sequencing of each item.
  oldv_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  // Storage, scan and result fields.
  oldv_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .value        (value),
    .sts          (sts),
    .status       (status),
    .occupancy    (occupancy),
    .removed_count(removed_count)
  );

endmodule

`default_nettype wire

// File: design/oldv_checker.sv
// Port-level checker for the ordered list block, bound to the top level.
// Depends on oldv_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_delete_by_value_top_defines.svh"

module oldv_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [1:0]            status,
  input wire logic [oldv_pkg::OUT_W-1:0] occupancy,
  input wire logic [oldv_pkg::OUT_W-1:0] removed_count
);
  import oldv_pkg::*;

  // An accepted item always keeps the block busy in the next cycle.
  `OLDV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")

  // A result is only shown while the block is ready for the next item.
  `OLDV_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

  // A dropped insert reports a full list and nothing removed.
  `OLDV_ASSERT_SAME(a_full_result, done && (status == ST_FULL), (removed_count == '0) && (occupancy == OUT_W'(CAPACITY)), "bad full-list result")

  // A removal without a match removes nothing.
  `OLDV_ASSERT_SAME(a_nomatch_result, done && (status == ST_NOMATCH), removed_count == '0, "no-match result with removals")

endmodule

bind ordered_list_delete_by_value_top oldv_checker #(
  .CAPACITY(CAPACITY)
) u_oldv_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .occupancy    (occupancy),
  .removed_count(removed_count)
);

`default_nettype wire
